/* hw/rtl/erp_pkg.sv */
// shared constants, types and the arctangent table for the point transform
// no dependencies
package erp_pkg;

  localparam int unsigned SineIterations = 16;
  localparam int unsigned AtanEntries = 24;
  localparam int unsigned NumSteps = (SineIterations < AtanEntries) ? SineIterations : AtanEntries;

  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [33:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [33:0] PiQ30 = 34'sd3373259426;
  localparam logic signed [34:0] TwoPiQ30 = 35'sd6746518852;
  localparam logic signed [31:0] OneQ30 = 32'sd1073741824;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw = 2;

  // one accepted item after the front stage
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
  } item_t;

  typedef struct packed {
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] mz;
  } result_t;

  // folded angle and flip flag
  typedef struct packed {
    logic signed [33:0] z;
    logic flip;
  } angle_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
    logic signed [33:0] r;
    r = '0;
    case (idx)
      5'd0: r = 34'sh3243F6A8;  5'd1: r = 34'sh1DAC6705;
      5'd2: r = 34'sh0FADBAFC;  5'd3: r = 34'sh07F56EA6;
      5'd4: r = 34'sh03FEAB76;  5'd5: r = 34'sh01FFD55B;
      5'd6: r = 34'sh00FFFAAA;  5'd7: r = 34'sh007FFF55;
      5'd8: r = 34'sh003FFFEA;  5'd9: r = 34'sh001FFFFD;
      5'd10: r = 34'sh000FFFFF; 5'd11: r = 34'sh0007FFFF;
      5'd12: r = 34'sh0003FFFF; 5'd13: r = 34'sh0001FFFF;
      5'd14: r = 34'sh0000FFFF; 5'd15: r = 34'sh00007FFF;
      5'd16: r = 34'sh00003FFF; 5'd17: r = 34'sh00001FFF;
      5'd18: r = 34'sh00000FFF; 5'd19: r = 34'sh000007FF;
      5'd20: r = 34'sh000003FF; 5'd21: r = 34'sh000001FF;
      5'd22: r = 34'sh000000FF; 5'd23: r = 34'sh0000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

  // range reduction into [-pi/2, pi/2]
  function automatic angle_t fold_angle(input logic signed [15:0] a);
    logic signed [34:0] z;
    angle_t r;
    z = 35'(a) <<< 18;
    if (z > 35'(PiQ30)) z = z - TwoPiQ30;
    else if (z < -35'(PiQ30)) z = z + TwoPiQ30;
    r.flip = 1'b0;
    if (z > 35'(HalfPiQ30)) begin
      z = z - 35'(PiQ30);
      r.flip = 1'b1;
    end else if (z < -35'(HalfPiQ30)) begin
      z = z + 35'(PiQ30);
      r.flip = 1'b1;
    end
    r.z = z[33:0];
    return r;
  endfunction

  // q30 product with round half up
  function automatic logic signed [33:0] mul_q30(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
    logic signed [67:0] p;
    p = 68'(a) * 68'(b) + 68'sd536870912;
    return 34'(p >>> 30);
  endfunction

  function automatic logic signed [31:0] clamp_unit(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'(OneQ30)) r = OneQ30;
    else if (v < -35'(OneQ30)) r = -OneQ30;
    else r = v[31:0];
    return r;
  endfunction

endpackage

/* hw/rtl/erp_front.sv */
// front stage: registers the item and folds the three angles into range
// depends on erp_pkg
module erp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  erp_pkg::item_t    item_i,
  input  logic              stall_i,
  output logic              out_valid_o,
  output erp_pkg::item_t    item_o,
  output erp_pkg::angle_t   roll_o,
  output erp_pkg::angle_t   pitch_o,
  output erp_pkg::angle_t   yaw_o
);

  logic valid_q;
  erp_pkg::item_t item_q;
  erp_pkg::angle_t roll_q, pitch_q, yaw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (!stall_i) valid_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (!stall_i) begin
      item_q  <= item_i;
      roll_q  <= erp_pkg::fold_angle(item_i.roll);
      pitch_q <= erp_pkg::fold_angle(item_i.pitch);
      yaw_q   <= erp_pkg::fold_angle(item_i.yaw);
    end
  end

  assign out_valid_o = valid_q;
  assign item_o = item_q;
  assign roll_o = roll_q;
  assign pitch_o = pitch_q;
  assign yaw_o = yaw_q;

endmodule

/* hw/rtl/erp_cordic.sv */
// pipelined cordic: one micro-rotation per stage for three angles, carries item along
// depends on erp_pkg
module erp_cordic (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              stall_i,
  input  logic              in_valid_i,
  input  erp_pkg::item_t    item_i,
  input  erp_pkg::angle_t   roll_i,
  input  erp_pkg::angle_t   pitch_i,
  input  erp_pkg::angle_t   yaw_i,
  output logic              out_valid_o,
  output erp_pkg::item_t    item_o,
  output logic signed [33:0] sin_o [3],
  output logic signed [33:0] cos_o [3]
);

  localparam int unsigned N = erp_pkg::NumSteps;

  // stage inputs: index 0 is the folded angle, index s+1 is register stage s
  logic                valid_s [N+1];
  erp_pkg::item_t      item_s  [N+1];
  logic signed [33:0]  x_s [N+1][3];
  logic signed [33:0]  y_s [N+1][3];
  logic signed [33:0]  z_s [N+1][3];
  logic                f_s [N+1][3];

  logic                valid_q [N];
  erp_pkg::item_t      item_q  [N];
  logic signed [33:0]  x_q [N][3];
  logic signed [33:0]  y_q [N][3];
  logic signed [33:0]  z_q [N][3];
  logic                f_q [N][3];

  always_comb begin
    valid_s[0] = in_valid_i;
    item_s[0] = item_i;
    x_s[0][0] = erp_pkg::CordicGain; y_s[0][0] = '0;
    z_s[0][0] = roll_i.z;  f_s[0][0] = roll_i.flip;
    x_s[0][1] = erp_pkg::CordicGain; y_s[0][1] = '0;
    z_s[0][1] = pitch_i.z; f_s[0][1] = pitch_i.flip;
    x_s[0][2] = erp_pkg::CordicGain; y_s[0][2] = '0;
    z_s[0][2] = yaw_i.z;   f_s[0][2] = yaw_i.flip;
    for (int s = 0; s < N; s++) begin
      valid_s[s+1] = valid_q[s];
      item_s[s+1] = item_q[s];
      for (int a = 0; a < 3; a++) begin
        x_s[s+1][a] = x_q[s][a];
        y_s[s+1][a] = y_q[s][a];
        z_s[s+1][a] = z_q[s][a];
        f_s[s+1][a] = f_q[s][a];
      end
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) valid_q[s] <= 1'b0;
      else if (!stall_i) valid_q[s] <= valid_s[s];
    end
    for (genvar a = 0; a < 3; a++) begin : g_ang
      always_ff @(posedge clk_i) begin
        if (!stall_i) begin
          if (!z_s[s][a][33]) begin
            x_q[s][a] <= x_s[s][a] - (y_s[s][a] >>> s);
            y_q[s][a] <= y_s[s][a] + (x_s[s][a] >>> s);
            z_q[s][a] <= z_s[s][a] - erp_pkg::atan_q30(5'(s));
          end else begin
            x_q[s][a] <= x_s[s][a] + (y_s[s][a] >>> s);
            y_q[s][a] <= y_s[s][a] - (x_s[s][a] >>> s);
            z_q[s][a] <= z_s[s][a] + erp_pkg::atan_q30(5'(s));
          end
          f_q[s][a] <= f_s[s][a];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (!stall_i) item_q[s] <= item_s[s];
    end
  end

  assign out_valid_o = valid_s[N];
  assign item_o = item_s[N];
  for (genvar a = 0; a < 3; a++) begin : g_out
    assign sin_o[a] = f_s[N][a] ? -y_s[N][a] : y_s[N][a];
    assign cos_o[a] = f_s[N][a] ? -x_s[N][a] : x_s[N][a];
  end

endmodule

/* hw/rtl/erp_back.sv */
// back end: matrix build, point product, translate and saturate, over pipeline stages
// depends on erp_pkg
module erp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               stall_i,
  input  logic               in_valid_i,
  input  erp_pkg::item_t     item_i,
  input  logic signed [33:0] sin_i [3],
  input  logic signed [33:0] cos_i [3],
  output logic               out_valid_o,
  output erp_pkg::result_t   res_o
);

  // stage 1: pair products
  logic v1_q, v2_q, v3_q, v4_q;
  erp_pkg::item_t it1_q, it2_q;
  logic signed [33:0] sr1_q, cr1_q, sp1_q, cp1_q, cysp_q, sysp_q, cycp_q, sycp_q;
  logic signed [33:0] sycr_q, sysr_q, cycr_q, cysr_q;
  logic signed [31:0] r_q [9];
  logic signed [34:0] e01, e02, e11, e12;
  logic signed [65:0] pr_q [9];
  logic signed [31:0] t3_q [3];
  erp_pkg::result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else if (!stall_i) begin
      v1_q <= in_valid_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_i) begin
      it1_q  <= item_i;
      sr1_q  <= sin_i[0]; cr1_q <= cos_i[0];
      sp1_q  <= sin_i[1]; cp1_q <= cos_i[1];
      cysp_q <= erp_pkg::mul_q30(cos_i[2], sin_i[1]);
      sysp_q <= erp_pkg::mul_q30(sin_i[2], sin_i[1]);
      cycp_q <= erp_pkg::mul_q30(cos_i[2], cos_i[1]);
      sycp_q <= erp_pkg::mul_q30(sin_i[2], cos_i[1]);
      sycr_q <= erp_pkg::mul_q30(sin_i[2], cos_i[0]);
      sysr_q <= erp_pkg::mul_q30(sin_i[2], sin_i[0]);
      cycr_q <= erp_pkg::mul_q30(cos_i[2], cos_i[0]);
      cysr_q <= erp_pkg::mul_q30(cos_i[2], sin_i[0]);
    end
  end

  always_comb begin
    e01 = 35'(erp_pkg::mul_q30(cysp_q, sr1_q)) - 35'(sycr_q);
    e02 = 35'(erp_pkg::mul_q30(cysp_q, cr1_q)) + 35'(sysr_q);
    e11 = 35'(erp_pkg::mul_q30(sysp_q, sr1_q)) + 35'(cycr_q);
    e12 = 35'(erp_pkg::mul_q30(sysp_q, cr1_q)) - 35'(cysr_q);
  end

  // stage 2: second products and clamp
  always_ff @(posedge clk_i) begin
    if (!stall_i) begin
      it2_q  <= it1_q;
      r_q[0] <= erp_pkg::clamp_unit(35'(cycp_q));
      r_q[1] <= erp_pkg::clamp_unit(e01);
      r_q[2] <= erp_pkg::clamp_unit(e02);
      r_q[3] <= erp_pkg::clamp_unit(35'(sycp_q));
      r_q[4] <= erp_pkg::clamp_unit(e11);
      r_q[5] <= erp_pkg::clamp_unit(e12);
      r_q[6] <= erp_pkg::clamp_unit(-35'(sp1_q));
      r_q[7] <= erp_pkg::clamp_unit(35'(erp_pkg::mul_q30(cp1_q, sr1_q)));
      r_q[8] <= erp_pkg::clamp_unit(35'(erp_pkg::mul_q30(cp1_q, cr1_q)));
    end
  end

  // stage 3: matrix times point
  always_ff @(posedge clk_i) begin
    if (!stall_i) begin
      for (int i = 0; i < 3; i++) begin
        pr_q[3*i]   <= 66'(r_q[3*i])   * 66'(it2_q.px);
        pr_q[3*i+1] <= 66'(r_q[3*i+1]) * 66'(it2_q.py);
        pr_q[3*i+2] <= 66'(r_q[3*i+2]) * 66'(it2_q.pz);
      end
      t3_q[0] <= it2_q.tx; t3_q[1] <= it2_q.ty; t3_q[2] <= it2_q.tz;
    end
  end

  // stage 4: sum, round, translate, saturate
  function automatic logic signed [31:0] finish(input logic signed [65:0] a,
                                                input logic signed [65:0] b,
                                                input logic signed [65:0] c,
                                                input logic signed [31:0] t);
    logic signed [65:0] s;
    logic signed [36:0] v;
    logic signed [31:0] r;
    s = a + b + c + 66'sd536870912;
    v = 37'(s >>> 30) + 37'(t);
    if (v > 37'sd2147483647) r = 32'sh7fffffff;
    else if (v < -37'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (!stall_i) begin
      res_q.mx <= finish(pr_q[0], pr_q[1], pr_q[2], t3_q[0]);
      res_q.my <= finish(pr_q[3], pr_q[4], pr_q[5], t3_q[1]);
      res_q.mz <= finish(pr_q[6], pr_q[7], pr_q[8], t3_q[2]);
    end
  end

  assign out_valid_o = v4_q;
  assign res_o = res_q;

endmodule

/* hw/rtl/erp_fifo.sv */
// small result queue that decouples the pipeline from the receiver
// depends on erp_pkg
module erp_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  erp_pkg::result_t data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic             full_o,
  output erp_pkg::result_t data_o
);

  erp_pkg::result_t mem_q [erp_pkg::FifoDepth];
  logic [erp_pkg::FifoAw-1:0] wr_q, rd_q;
  logic [erp_pkg::FifoAw:0] cnt_q;
  logic do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o = (cnt_q == (erp_pkg::FifoAw+1)'(erp_pkg::FifoDepth));
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (erp_pkg::FifoAw+1)'(do_push) - (erp_pkg::FifoAw+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

/* hw/rtl/euler_rotate_translate_point.sv */
// top level: zyx euler rotation and translation of one point per item
// depends on erp_pkg, erp_front, erp_cordic, erp_back, erp_fifo
//
// usage: push an item when full is low; results come out in order on the
// moved_* ports while empty is low, and are taken with pop.
// stages: the front stage (angle folding), 16 cordic stages (one micro-rotation
// each, all three angles in parallel), 4 back stages (matrix products, point
// product, round/translate/saturate), then the result queue.
// throughput: one item per cycle while full is low.
// the pipeline advances while the result queue can still take the item
// leaving it; when the receiver stalls the queue fills, the pipeline
// freezes and full rises.
// reset clears all valid flags and the queue; no clearing pass is needed.
module euler_rotate_translate_point (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic signed [15:0] roll_angle_i,
  input  logic signed [15:0] pitch_angle_i,
  input  logic signed [15:0] yaw_angle_i,
  input  logic signed [31:0] shift_x_i,
  input  logic signed [31:0] shift_y_i,
  input  logic signed [31:0] shift_z_i,
  output logic        empty,
  input  logic        pop,
  output logic signed [31:0] moved_x_o,
  output logic signed [31:0] moved_y_o,
  output logic signed [31:0] moved_z_o
);

  erp_pkg::item_t in_item, f_item, c_item;
  erp_pkg::angle_t roll_a, pitch_a, yaw_a;
  erp_pkg::result_t b_res, q_res;
  logic f_valid, c_valid, b_valid, q_full, q_empty, stall;
  logic signed [33:0] sin_w [3];
  logic signed [33:0] cos_w [3];

  assign in_item = '{px: point_x_i, py: point_y_i, pz: point_z_i,
                     roll: roll_angle_i, pitch: pitch_angle_i, yaw: yaw_angle_i,
                     tx: shift_x_i, ty: shift_y_i, tz: shift_z_i};

  // freeze only when the last stage holds a word the queue cannot take
  assign stall = b_valid && q_full;
  assign full = stall;

  erp_front u_front (
    .clk_i, .rst_ni, .in_valid_i(push), .item_i(in_item), .stall_i(stall),
    .out_valid_o(f_valid), .item_o(f_item), .roll_o(roll_a), .pitch_o(pitch_a),
    .yaw_o(yaw_a)
  );

  erp_cordic u_cordic (
    .clk_i, .rst_ni, .stall_i(stall), .in_valid_i(f_valid), .item_i(f_item),
    .roll_i(roll_a), .pitch_i(pitch_a), .yaw_i(yaw_a), .out_valid_o(c_valid),
    .item_o(c_item), .sin_o(sin_w), .cos_o(cos_w)
  );

  erp_back u_back (
    .clk_i, .rst_ni, .stall_i(stall), .in_valid_i(c_valid), .item_i(c_item),
    .sin_i(sin_w), .cos_i(cos_w), .out_valid_o(b_valid), .res_o(b_res)
  );

  erp_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(b_valid), .data_i(b_res), .pop_i(pop),
    .empty_o(q_empty), .full_o(q_full), .data_o(q_res)
  );

  assign empty = q_empty;
  assign moved_x_o = q_res.mx;
  assign moved_y_o = q_res.my;
  assign moved_z_o = q_res.mz;

endmodule

/* bench/tb_euler_rotate_translate_point.sv */
// testbench for euler_rotate_translate_point: directed and random points, angles and shifts
// predicts each transformed point with its own cordic and matrix model; depends on the rtl only
`timescale 1ns / 1ps

module tb_euler_rotate_translate_point;

  localparam int Iters = 16;
  localparam longint Gain = 652032874;
  localparam longint HalfPi = 1686629713;
  localparam longint Pi = 2 * HalfPi;
  localparam longint TwoPi = 4 * HalfPi;
  localparam longint OneQ = 1073741824;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic empty;
  logic pop = 1'b0;
  logic signed [31:0] point_x_i = '0, point_y_i = '0, point_z_i = '0;
  logic signed [15:0] roll_angle_i = '0, pitch_angle_i = '0, yaw_angle_i = '0;
  logic signed [31:0] shift_x_i = '0, shift_y_i = '0, shift_z_i = '0;
  logic signed [31:0] moved_x_o, moved_y_o, moved_z_o;

  typedef struct {
    logic signed [31:0] mx, my, mz;
  } moved_t;

  moved_t moved_q[$];
  int errors = 0;
  int words_sent = 0;
  int words_got = 0;

  euler_rotate_translate_point uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .point_x_i(point_x_i), .point_y_i(point_y_i), .point_z_i(point_z_i),
    .roll_angle_i(roll_angle_i), .pitch_angle_i(pitch_angle_i), .yaw_angle_i(yaw_angle_i),
    .shift_x_i(shift_x_i), .shift_y_i(shift_y_i), .shift_z_i(shift_z_i),
    .empty(empty), .pop(pop),
    .moved_x_o(moved_x_o), .moved_y_o(moved_y_o), .moved_z_o(moved_z_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint atan_entry(int i);
    longint tbl[24] = '{
      'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
      'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
      'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
      'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F};
    return tbl[i];
  endfunction

  // arithmetic shift of a signed longint is a floor
  function automatic longint qmul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint unit_clamp(longint v);
    if (v > OneQ) return OneQ;
    if (v < -OneQ) return -OneQ;
    return v;
  endfunction

  task automatic angle_sin_cos(input logic signed [15:0] a, output longint s, output longint c);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(a) * 262144;
    x = Gain;
    y = 0;
    flip = 1'b0;
    if (z > Pi) z -= TwoPi;
    else if (z < -Pi) z += TwoPi;
    if (z > HalfPi) begin
      z -= Pi;
      flip = 1'b1;
    end else if (z < -HalfPi) begin
      z += Pi;
      flip = 1'b1;
    end
    for (int i = 0; i < Iters && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endtask

  task automatic predict_moved(input longint p[3], input logic signed [15:0] ro,
                               input logic signed [15:0] pi_a, input logic signed [15:0] ya,
                               input longint t[3], output moved_t m);
    longint sr, cr, sp, cp, sy, cy, acc, v;
    longint r[3][3];
    longint res[3];
    angle_sin_cos(ro, sr, cr);
    angle_sin_cos(pi_a, sp, cp);
    angle_sin_cos(ya, sy, cy);
    r[0][0] = qmul(cy, cp);
    r[0][1] = qmul(qmul(cy, sp), sr) - qmul(sy, cr);
    r[0][2] = qmul(qmul(cy, sp), cr) + qmul(sy, sr);
    r[1][0] = qmul(sy, cp);
    r[1][1] = qmul(qmul(sy, sp), sr) + qmul(cy, cr);
    r[1][2] = qmul(qmul(sy, sp), cr) - qmul(cy, sr);
    r[2][0] = -sp;
    r[2][1] = qmul(cp, sr);
    r[2][2] = qmul(cp, cr);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += unit_clamp(r[i][j]) * p[j];
      v = ((acc + (64'sd1 <<< 29)) >>> 30) + t[i];
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      res[i] = v;
    end
    m.mx = res[0][31:0];
    m.my = res[1][31:0];
    m.mz = res[2][31:0];
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // drive one word and wait until it is taken
  task automatic send_point(input logic signed [31:0] px, py, pz,
                            input logic signed [15:0] ro, pa, ya,
                            input logic signed [31:0] tx, ty, tz);
    longint p[3], t[3];
    moved_t m;
    point_x_i <= px; point_y_i <= py; point_z_i <= pz;
    roll_angle_i <= ro; pitch_angle_i <= pa; yaw_angle_i <= ya;
    shift_x_i <= tx; shift_y_i <= ty; shift_z_i <= tz;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    p = '{longint'(px), longint'(py), longint'(pz)};
    t = '{longint'(tx), longint'(ty), longint'(tz)};
    predict_moved(p, ro, pa, ya, t, m);
    moved_q.push_back(m);
    words_sent++;
    @(negedge clk_i);
    if (sending_gap()) push <= 1'b0;
  endtask

  int pending_gap = 0;

  function automatic bit sending_gap();
    pending_gap = gap_len();
    return pending_gap != 0;
  endfunction

  task automatic idle_sender();
    repeat (pending_gap) @(negedge clk_i);
    pending_gap = 0;
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 32'h0003FFFF)) - 32'sh00020000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return $signed(16'($urandom_range(0, 16'h3200))) - 16'sh1900;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic signed [15:0] angs[10] = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh3244,
                                      -16'sh3244, 16'sh1922, -16'sh1922, 16'sh1921,
                                      16'sh6488, 16'sh0001};
    send_point(32'sh00010000, 32'sh00020000, 32'sh00030000, 0, 0, 0, 0, 0, 0);
    idle_sender();
    send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 0,
               32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    idle_sender();
    send_point(32'sh80000000, 32'sh80000000, 32'sh80000000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
               32'sh80000000, 32'sh80000000, 32'sh80000000);
    idle_sender();
    for (int i = 0; i < 10; i++) begin
      send_point(32'sh00010000, 32'shFFFF0000, 32'sh7FFFFFFF, angs[i], angs[(i + 3) % 10],
                 angs[(i + 7) % 10], 32'sh7FFF0000, 32'sh80000000, 32'sh00000001);
      idle_sender();
    end
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      send_point(rand_coord(), rand_coord(), rand_coord(), rand_angle(), rand_angle(),
                 rand_angle(), rand_coord(), rand_coord(), rand_coord());
      idle_sender();
    end
  endtask

  // result side: random pop with stalls, check at the rising edge
  initial begin
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 99) < 3) begin
        pop <= 1'b0;
        repeat ($urandom_range(10, 40)) @(negedge clk_i);
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(0, 99) < 76);
      end
    end
  end

  always @(posedge clk_i) begin
    moved_t m;
    if (rst_ni && pop && !empty) begin
      words_got++;
      if (moved_q.size() == 0) begin
        $error("unexpected word moved_x %0d moved_y %0d moved_z %0d",
               moved_x_o, moved_y_o, moved_z_o);
        errors++;
      end else begin
        m = moved_q.pop_front();
        if (moved_x_o !== m.mx) begin
          $error("moved_x expected %0d actual %0d", m.mx, moved_x_o);
          errors++;
        end
        if (moved_y_o !== m.my) begin
          $error("moved_y expected %0d actual %0d", m.my, moved_y_o);
          errors++;
        end
        if (moved_z_o !== m.mz) begin
          $error("moved_z expected %0d actual %0d", m.mz, moved_z_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(2000);
    push <= 1'b0;
    while (moved_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (moved_q.size() != 0) errors++;
    $display("sent %0d points with extreme and random coordinates, angles and shifts",
             words_sent);
    $display("checked %0d transformed points under random push and pop stalls", words_got);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/erp_pkg.sv
hw/rtl/erp_front.sv
hw/rtl/erp_cordic.sv
hw/rtl/erp_back.sv
hw/rtl/erp_fifo.sv
hw/rtl/euler_rotate_translate_point.sv
bench/tb_euler_rotate_translate_point.sv
